// File: hdl/fbc_pkg.sv
// Shared types, opcode groups and fault codes for the four-bit core.
`default_nettype none
package fbc_pkg;
    localparam int PROGRAM_DEPTH_DEF  = 4096;
    localparam int STACK_LEVELS_DEF   = 3;
    localparam int REGISTER_COUNT_DEF = 16;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_STEP = 1'b1;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
    localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;

    localparam logic [3:0] GRP_JCN = 4'h1;
    localparam logic [3:0] GRP_FIM = 4'h2;
    localparam logic [3:0] GRP_FIN = 4'h3;
    localparam logic [3:0] GRP_JUN = 4'h4;
    localparam logic [3:0] GRP_JMS = 4'h5;
    localparam logic [3:0] GRP_INC = 4'h6;
    localparam logic [3:0] GRP_ISZ = 4'h7;
    localparam logic [3:0] GRP_ADD = 4'h8;
    localparam logic [3:0] GRP_SUB = 4'h9;
    localparam logic [3:0] GRP_LD  = 4'hA;
    localparam logic [3:0] GRP_XCH = 4'hB;
    localparam logic [3:0] GRP_BBL = 4'hC;
    localparam logic [3:0] GRP_LDM = 4'hD;
    localparam logic [3:0] GRP_WRM = 4'hE;
    localparam logic [3:0] GRP_ACC = 4'hF;

    localparam logic [11:0] PAGE_MASK = 12'hF00;

    typedef struct packed {
        logic        operation;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
    } fbc_in_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [3:0]  accumulator_value;
        logic        carry_value;
        logic [7:0]  executed_opcode;
        logic [1:0]  fault;
    } fbc_out_t;
endpackage
`default_nettype wire

// File: hdl/fbc_stream_if.sv
// Valid/ready channel carrying one word of type T.
`default_nettype none
interface fbc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/fbc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module fbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: hdl/fbc_front.sv
// Front end: accepts input words into a two-entry queue.
`default_nettype none
module fbc_front import fbc_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    fbc_stream_if.sink   in_s,
    fbc_stream_if.source q_s
);
    fbc_in_t    buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push, pop;

    assign in_s.ready = (cnt_reg != 2'd2);
    assign push       = in_s.valid && in_s.ready;
    assign q_s.valid  = (cnt_reg != 2'd0);
    assign q_s.data   = buf_reg[rd_reg];
    assign pop        = q_s.valid && q_s.ready;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_s.data;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count step");
endmodule
`default_nettype wire

// File: hdl/fbc_back.sv
// Back end: sequencer that executes loads and instructions against program memory.
`default_nettype none
module fbc_back import fbc_pkg::*; #(
    parameter int PROGRAM_DEPTH  = PROGRAM_DEPTH_DEF,
    parameter int STACK_LEVELS   = STACK_LEVELS_DEF,
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fbc_stream_if.sink   q_s,
    fbc_stream_if.source out_s
);
    localparam int AW = $clog2(PROGRAM_DEPTH);
    localparam int SW = $clog2(STACK_LEVELS + 1);
    localparam int SI = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_B2   = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]  st_reg, st_next;
    logic [3:0]  regs_reg [REGISTER_COUNT];
    logic [3:0]  acc_reg, acc_next;
    logic        cy_reg, cy_next;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] stk_reg [STACK_LEVELS];
    logic [SW-1:0] lvl_reg, lvl_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  b2_reg, b2_next;
    fbc_out_t    out_reg, out_next;
    logic        ov_reg, ov_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    wdata, rdata;

    logic        take;
    logic [3:0]  hi, lo;
    logic [11:0] nxt1, nxt2, page1, page2;
    logic [11:0] fin_addr, wrm_addr;
    logic [4:0]  t5;
    logic        cond;
    logic [3:0]  rlo, rinc;
    logic        reg_we, reg_we2;
    logic [3:0]  reg_wi, reg_wi2, reg_wv, reg_wv2;
    logic        push_stk;
    logic [1:0]  flt;

    fbc_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_mem (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign out_s.valid = ov_reg;
    assign out_s.data  = out_reg;
    // accept a new word only in idle and when the output slot is free or draining
    assign take      = (st_reg == S_IDLE) && q_s.valid && (!ov_reg || out_s.ready);
    assign q_s.ready = (st_reg == S_IDLE) && (!ov_reg || out_s.ready);

    assign hi       = op_reg[7:4];
    assign lo       = op_reg[3:0];
    assign nxt1     = pc_reg + 12'd1;
    assign nxt2     = pc_reg + 12'd2;
    assign page1    = nxt1 & PAGE_MASK;
    assign page2    = nxt2 & PAGE_MASK;
    assign fin_addr = page1 | {4'd0, regs_reg[0], regs_reg[1]};
    assign wrm_addr = page2 | {4'd0, b2_reg};
    assign rlo      = regs_reg[lo];
    assign rinc     = rlo + 4'd1;

    always_comb
    begin
        st_next  = st_reg;
        acc_next = acc_reg;
        cy_next  = cy_reg;
        pc_next  = pc_reg;
        lvl_next = lvl_reg;
        op_next  = op_reg;
        b2_next  = b2_reg;
        out_next = out_reg;
        ov_next  = ov_reg && !out_s.ready;
        we       = 1'b0;
        addr     = pc_reg[AW-1:0];
        wdata    = q_s.data.load_byte;
        reg_we   = 1'b0;
        reg_we2  = 1'b0;
        reg_wi   = lo;
        reg_wi2  = lo | 4'd1;
        reg_wv   = '0;
        reg_wv2  = '0;
        push_stk = 1'b0;
        flt      = FAULT_NONE;
        t5       = '0;
        cond     = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (q_s.data.operation == OP_LOAD)
                    begin
                        we   = 1'b1;
                        addr = q_s.data.load_address[AW-1:0];
                        out_next = '{pc_reg, acc_reg, cy_reg, 8'd0, FAULT_NONE};
                        ov_next  = 1'b1;
                    end
                    else
                    begin
                        addr    = pc_reg[AW-1:0];
                        st_next = S_OP;
                    end
                end
            end
            S_OP:
            begin
                addr    = nxt1[AW-1:0];
                op_next = rdata;
                st_next = S_B2;
            end
            S_B2:
            begin
                // second byte arrives; FIN table fetch goes out as the third read
                b2_next = rdata;
                addr    = fin_addr[AW-1:0];
                st_next = (hi == GRP_FIN && !lo[0]) ? S_FIN : S_EXEC;
            end
            S_EXEC, S_FIN:
            begin
                pc_next = nxt1;
                unique case (hi)
                    GRP_JCN:
                    begin
                        cond = (lo[2] && acc_reg == 4'd0) || (lo[1] && cy_reg);
                        if (lo[3]) cond = !cond;
                        pc_next = cond ? (page2 | {4'd0, b2_reg}) : nxt2;
                    end
                    GRP_FIM:
                    begin
                        if (!lo[0])
                        begin
                            reg_we = 1'b1; reg_wv = b2_reg[7:4];
                            reg_we2 = 1'b1; reg_wv2 = b2_reg[3:0];
                            pc_next = nxt2;
                        end
                    end
                    GRP_FIN:
                    begin
                        if (lo[0])
                        begin
                            pc_next = page1 | {4'd0, regs_reg[lo & 4'hE], regs_reg[lo]};
                        end
                        else
                        begin
                            // in S_FIN the RAM data is the table byte
                            reg_we = 1'b1; reg_wv = rdata[7:4];
                            reg_we2 = 1'b1; reg_wv2 = rdata[3:0];
                        end
                    end
                    GRP_JUN: pc_next = {lo, b2_reg};
                    GRP_JMS:
                    begin
                        if (lvl_reg >= SW'(STACK_LEVELS))
                        begin
                            flt = FAULT_OVERFLOW;
                            pc_next = nxt2;
                        end
                        else
                        begin
                            push_stk = 1'b1;
                            lvl_next = lvl_reg + SW'(1);
                            pc_next  = {lo, b2_reg};
                        end
                    end
                    GRP_INC:
                    begin
                        reg_we = 1'b1; reg_wv = rinc;
                    end
                    GRP_ISZ:
                    begin
                        reg_we = 1'b1; reg_wv = rinc;
                        pc_next = (rinc != 4'd0) ? (page2 | {4'd0, b2_reg}) : nxt2;
                    end
                    GRP_ADD:
                    begin
                        t5 = {1'b0, acc_reg} + {1'b0, rlo} + {4'd0, cy_reg};
                        acc_next = t5[3:0]; cy_next = t5[4];
                    end
                    GRP_SUB:
                    begin
                        t5 = {1'b0, acc_reg} + {1'b0, ~rlo} + {4'd0, !cy_reg};
                        acc_next = t5[3:0]; cy_next = t5[4];
                    end
                    GRP_LD: acc_next = rlo;
                    GRP_XCH:
                    begin
                        acc_next = rlo;
                        reg_we = 1'b1; reg_wv = acc_reg;
                    end
                    GRP_BBL:
                    begin
                        if (lvl_reg == '0)
                        begin
                            flt = FAULT_UNDERFLOW;
                        end
                        else
                        begin
                            lvl_next = lvl_reg - SW'(1);
                            pc_next  = stk_reg[SI'(lvl_reg - SW'(1))];
                            acc_next = lo;
                        end
                    end
                    GRP_LDM: acc_next = lo;
                    GRP_WRM:
                    begin
                        we      = 1'b1;
                        addr    = wrm_addr[AW-1:0];
                        wdata   = {4'd0, rlo};
                        pc_next = nxt2;
                    end
                    GRP_ACC:
                    begin
                        unique case (lo)
                            4'h0: begin acc_next = '0; cy_next = 1'b0; end
                            4'h1: cy_next = 1'b0;
                            4'h2:
                            begin
                                t5 = {1'b0, acc_reg} + 5'd1;
                                acc_next = t5[3:0]; cy_next = t5[4];
                            end
                            4'h3: cy_next = !cy_reg;
                            4'h4: acc_next = ~acc_reg;
                            4'h5: begin acc_next = {acc_reg[2:0], cy_reg}; cy_next = acc_reg[3]; end
                            4'h6: begin acc_next = {cy_reg, acc_reg[3:1]}; cy_next = acc_reg[0]; end
                            4'h7: begin acc_next = {3'd0, cy_reg}; cy_next = 1'b0; end
                            4'h8:
                            begin
                                cy_next  = (acc_reg != 4'd0);
                                acc_next = acc_reg + 4'd15;
                            end
                            4'h9: begin acc_next = cy_reg ? 4'd10 : 4'd9; cy_next = 1'b0; end
                            4'hA: cy_next = 1'b1;
                            4'hB:
                            begin
                                if (acc_reg > 4'd9 || cy_reg)
                                begin
                                    t5 = {1'b0, acc_reg} + 5'd6;
                                    acc_next = t5[3:0];
                                    if (t5[4]) cy_next = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                out_next = '{pc_next, acc_next, cy_next, op_reg, flt};
                ov_next  = 1'b1;
                st_next  = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            acc_reg <= '0;
            cy_reg  <= 1'b0;
            pc_reg  <= '0;
            lvl_reg <= '0;
            ov_reg  <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg  <= st_next;
            acc_reg <= acc_next;
            cy_reg  <= cy_next;
            pc_reg  <= pc_next;
            lvl_reg <= lvl_next;
            ov_reg  <= ov_next;
            if (reg_we)  regs_reg[reg_wi]  <= reg_wv;
            if (reg_we2) regs_reg[reg_wi2] <= reg_wv2;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        b2_reg  <= b2_next;
        out_reg <= out_next;
        if (push_stk)
        begin
            stk_reg[SI'(lvl_reg)] <= nxt2;
        end
    end

    a_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= SW'(STACK_LEVELS)) else $error("stack level out of range");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_s.ready |-> st_reg == S_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_s.ready |=> ov_reg && $stable(out_reg)) else $error("result lost");
endmodule
`default_nettype wire

// File: hdl/four_bit_cpu_instruction_execute.sv
// Top level of the four-bit instruction execute core.
// Usage:
//   in  : words {operation, load_address, load_byte}. operation 0 loads a
//         program byte, 1 executes the instruction at PC.
//   out : one word per input word {program_counter, accumulator_value,
//         carry_value, executed_opcode, fault}.
// A two-entry queue in the front end accepts words while the back end works.
// Sequence: a load is handled in the back end's accept state; every instruction
// steps through accept and opcode read, second byte read, FIN table read and
// execute; the single program memory port sets this sequence.
// Sustained rate: one load per cycle while the receiver is ready; an instruction
// is taken only after the previous one finishes. A load's result is valid in the
// cycle after its accept, an instruction's after its execute state; queue waits add.
// Reset clears PC, accumulator, carry, index registers, stack level and
// queue; program memory and return stack keep whatever they held.
// When the receiver stalls the result holds in the output register; the
// back end stops at its next word and the queue then fills, after which
// input ready drops.
`default_nettype none
module four_bit_cpu_instruction_execute import fbc_pkg::*; #(
    parameter int PROGRAM_DEPTH  = PROGRAM_DEPTH_DEF,
    parameter int STACK_LEVELS   = STACK_LEVELS_DEF,
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    fbc_stream_if.sink   in_ch,
    fbc_stream_if.source out_ch
);
    fbc_stream_if #(.T(fbc_in_t)) q_ch ();

    fbc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_s(in_ch), .q_s(q_ch)
    );

    fbc_back #(
        .PROGRAM_DEPTH(PROGRAM_DEPTH),
        .STACK_LEVELS(STACK_LEVELS),
        .REGISTER_COUNT(REGISTER_COUNT)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_s(q_ch), .out_s(out_ch)
    );
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the four-bit instruction execute core.
`default_nettype none
module tb_top;
    import fbc_pkg::*;

    localparam int TARGET_WORDS = 1700;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;

    fbc_stream_if #(.T(fbc_in_t))  in_ch ();
    fbc_stream_if #(.T(fbc_out_t)) out_ch ();

    four_bit_cpu_instruction_execute dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow machine state, advanced while the stimulus is built.
    logic [7:0]  prog_mem [PROGRAM_DEPTH_DEF];
    bit          mem_loaded [PROGRAM_DEPTH_DEF];
    logic [3:0]  idx_reg [REGISTER_COUNT_DEF];
    logic [3:0]  acc_q;
    logic        cy_q;
    logic [11:0] pc_q;
    logic [11:0] ret_stack [STACK_LEVELS_DEF];
    int          sp_q;

    fbc_in_t  pending_words [$];
    fbc_out_t expected_results [$];
    int       words_sent;
    int       results_seen;
    int       mismatches;

    // Executes one word on the shadow state; returns the expected result.
    function automatic fbc_out_t execute_word(fbc_in_t w);
        fbc_out_t    r;
        logic [7:0]  op;
        logic [7:0]  b2;
        logic [7:0]  tb;
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic [11:0] nxt1;
        logic [11:0] nxt2;
        logic [11:0] addr;
        logic [4:0]  sum;
        logic [3:0]  tmp;
        logic        cond;
        logic [1:0]  flt;
        op  = 8'h00;
        flt = FAULT_NONE;
        if (w.operation == OP_LOAD)
        begin
            prog_mem[w.load_address]   = w.load_byte;
            mem_loaded[w.load_address] = 1'b1;
        end
        else
        begin
            op   = prog_mem[pc_q];
            hi   = op[7:4];
            lo   = op[3:0];
            nxt1 = pc_q + 12'd1;
            nxt2 = pc_q + 12'd2;
            b2   = prog_mem[nxt1];
            pc_q = nxt1;
            case (hi)
                GRP_JCN:
                begin
                    cond = (lo[2] && acc_q == 4'd0) || (lo[1] && cy_q);
                    if (lo[3])
                        cond = !cond;
                    pc_q = cond ? {nxt2[11:8], b2} : nxt2;
                end
                GRP_FIM:
                    if (!lo[0])
                    begin
                        idx_reg[lo]        = b2[7:4];
                        idx_reg[lo + 4'd1] = b2[3:0];
                        pc_q = nxt2;
                    end
                GRP_FIN:
                    if (lo[0])
                        pc_q = {nxt1[11:8], idx_reg[lo & 4'hE], idx_reg[lo | 4'h1]};
                    else
                    begin
                        tb = prog_mem[{nxt1[11:8], idx_reg[0], idx_reg[1]}];
                        idx_reg[lo]        = tb[7:4];
                        idx_reg[lo + 4'd1] = tb[3:0];
                    end
                GRP_JUN: pc_q = {lo, b2};
                GRP_JMS:
                    if (sp_q >= STACK_LEVELS_DEF)
                    begin
                        flt  = FAULT_OVERFLOW;
                        pc_q = nxt2;
                    end
                    else
                    begin
                        ret_stack[sp_q] = nxt2;
                        sp_q = sp_q + 1;
                        pc_q = {lo, b2};
                    end
                GRP_INC: idx_reg[lo] = idx_reg[lo] + 4'd1;
                GRP_ISZ:
                begin
                    idx_reg[lo] = idx_reg[lo] + 4'd1;
                    pc_q = (idx_reg[lo] != 4'd0) ? {nxt2[11:8], b2} : nxt2;
                end
                GRP_ADD:
                begin
                    sum   = acc_q + idx_reg[lo] + cy_q;
                    acc_q = sum[3:0];
                    cy_q  = sum[4];
                end
                GRP_SUB:
                begin
                    // borrow-in is the inverted carry
                    sum   = {1'b0, acc_q} + {1'b0, ~idx_reg[lo]} + {4'd0, !cy_q};
                    acc_q = sum[3:0];
                    cy_q  = sum[4];
                end
                GRP_LD:  acc_q = idx_reg[lo];
                GRP_XCH:
                begin
                    tmp         = acc_q;
                    acc_q       = idx_reg[lo];
                    idx_reg[lo] = tmp;
                end
                GRP_BBL:
                    if (sp_q == 0)
                        flt = FAULT_UNDERFLOW;
                    else
                    begin
                        sp_q  = sp_q - 1;
                        pc_q  = ret_stack[sp_q];
                        acc_q = lo;
                    end
                GRP_LDM: acc_q = lo;
                GRP_WRM:
                begin
                    addr             = {nxt2[11:8], b2};
                    prog_mem[addr]   = {4'h0, idx_reg[lo]};
                    mem_loaded[addr] = 1'b1;
                    pc_q = nxt2;
                end
                GRP_ACC:
                    case (lo)
                        4'h0: begin acc_q = 4'd0; cy_q = 1'b0; end
                        4'h1: cy_q = 1'b0;
                        4'h2: begin sum = acc_q + 5'd1; acc_q = sum[3:0]; cy_q = sum[4]; end
                        4'h3: cy_q = !cy_q;
                        4'h4: acc_q = ~acc_q;
                        4'h5: begin tmp = acc_q; acc_q = {tmp[2:0], cy_q}; cy_q = tmp[3]; end
                        4'h6: begin tmp = acc_q; acc_q = {cy_q, tmp[3:1]}; cy_q = tmp[0]; end
                        4'h7: begin acc_q = {3'b0, cy_q}; cy_q = 1'b0; end
                        4'h8: begin cy_q = (acc_q != 4'd0); acc_q = acc_q - 4'd1; end
                        4'h9: begin acc_q = cy_q ? 4'd10 : 4'd9; cy_q = 1'b0; end
                        4'hA: cy_q = 1'b1;
                        4'hB:
                            if (acc_q > 4'd9 || cy_q)
                            begin
                                sum   = acc_q + 5'd6;
                                acc_q = sum[3:0];
                                if (sum[4])
                                    cy_q = 1'b1;
                            end
                        default: ;
                    endcase
                default: ;
            endcase
        end
        r.program_counter   = pc_q;
        r.accumulator_value = acc_q;
        r.carry_value       = cy_q;
        r.executed_opcode   = op;
        r.fault             = flt;
        return r;
    endfunction

    task automatic queue_word(fbc_in_t w);
        pending_words.push_back(w);
        expected_results.push_back(execute_word(w));
    endtask

    task automatic queue_load(logic [11:0] a, logic [7:0] b);
        fbc_in_t w;
        w.operation    = OP_LOAD;
        w.load_address = a;
        w.load_byte    = b;
        queue_word(w);
    endtask

    // Loads a random byte where the core would otherwise fetch unwritten memory.
    task automatic fill_if_unloaded(logic [11:0] a);
        if (!mem_loaded[a])
            queue_load(a, 8'($urandom));
    endtask

    // Makes every byte the next instruction fetches valid, then steps once.
    task automatic queue_step();
        fbc_in_t    w;
        logic [7:0] op;
        fill_if_unloaded(pc_q);
        fill_if_unloaded(pc_q + 12'd1);
        op = prog_mem[pc_q];
        if (op[7:4] == GRP_FIN && !op[0])
            fill_if_unloaded({pc_q[11:8] + ((pc_q[7:0] == 8'hFF) ? 4'd1 : 4'd0),
                              idx_reg[0], idx_reg[1]});
        w.operation    = OP_STEP;
        w.load_address = 12'($urandom);
        w.load_byte    = 8'($urandom);
        queue_word(w);
    endtask

    // Plants a chosen instruction at pc and runs it.
    task automatic planted_step(logic [7:0] op, logic [7:0] b2);
        queue_load(pc_q, op);
        queue_load(pc_q + 12'd1, b2);
        queue_step();
    endtask

    // Idle pattern per phase: none, sender 59%, receiver 59%, both 19%.
    function automatic int phase_of(int n);
        return (n * 4) / (TARGET_WORDS + 30);
    endfunction

    function automatic bit send_gap(int n);
        int ph;
        ph = phase_of(n);
        if (ph == 1)
            return $urandom_range(99) < 59;
        if (ph >= 3)
            return $urandom_range(99) < 19;
        return 1'b0;
    endfunction

    function automatic bit recv_stall(int n);
        int ph;
        ph = phase_of(n);
        if (ph == 2)
            return $urandom_range(99) < 59;
        if (ph >= 3)
            return $urandom_range(99) < 19;
        return 1'b0;
    endfunction

    // Driver: keeps a word on the channel until the core takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            words_sent  <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
                words_sent <= words_sent + 1;
            if (pending_words.size() != 0 && !send_gap(words_sent))
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_words.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !recv_stall(results_seen);
    end

    // Monitor: each accepted result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        fbc_out_t want;
        fbc_out_t got;
        if (!rst_n)
        begin
            results_seen <= 0;
            mismatches   <= 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            got          = out_ch.data;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d with nothing expected: %p", results_seen, got);
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.program_counter   !== want.program_counter   ||
                    got.accumulator_value !== want.accumulator_value ||
                    got.carry_value       !== want.carry_value       ||
                    got.executed_opcode   !== want.executed_opcode   ||
                    got.fault             !== want.fault)
                begin
                    if (mismatches < 10)
                        $display({"word %0d: expected pc=%h acc=%h c=%b op=%h f=%0d,",
                                  " got pc=%h acc=%h c=%b op=%h f=%0d"},
                                 results_seen, want.program_counter, want.accumulator_value,
                                 want.carry_value, want.executed_opcode, want.fault,
                                 got.program_counter, got.accumulator_value,
                                 got.carry_value, got.executed_opcode, got.fault);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    initial
    begin
        int k;
        // shadow reset
        for (k = 0; k < REGISTER_COUNT_DEF; k++)
            idx_reg[k] = 4'd0;
        acc_q = 4'd0;
        cy_q  = 1'b0;
        pc_q  = 12'd0;
        sp_q  = 0;

        // Directed: stack underflow first, then flags, BCD, and overflow.
        queue_load(12'hFFF, 8'hFF);
        planted_step({GRP_BBL, 4'h0}, 8'h00);   // return with an empty stack
        planted_step({GRP_LDM, 4'hF}, 8'hFF);
        planted_step({GRP_ACC, 4'h2}, 8'h00);   // increment wraps, carry set
        planted_step({GRP_SUB, 4'h3}, 8'h00);
        planted_step({GRP_ACC, 4'hB}, 8'h00);   // decimal adjust
        planted_step({GRP_JMS, 4'h1}, 8'h20);
        planted_step({GRP_JMS, 4'h2}, 8'h40);
        planted_step({GRP_JMS, 4'h3}, 8'h60);
        planted_step({GRP_JMS, 4'h4}, 8'h80);   // stack full
        planted_step({GRP_BBL, 4'h5}, 8'h00);

        // Random: mostly executed code, with stray loads as noise.
        while (pending_words.size() < TARGET_WORDS)
        begin
            if ($urandom_range(9) == 0)
                queue_load(12'($urandom), 8'($urandom));
            else
                queue_step();
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() == 0 && !in_ch.valid && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
